@@ design/rc4_pkg.sv @@
// Shared constants and types for the RC4 byte cipher.
package rc4_pkg;

  localparam int BYTE_W          = 8;
  localparam int PERM_DEPTH      = 256;
  localparam int PERM_AW         = $clog2(PERM_DEPTH);
  localparam int KEY_WORDS       = 4;
  localparam int KEY_WORD_W      = 64;
  localparam int KEY_BYTES_TOTAL = KEY_WORDS * KEY_WORD_W / BYTE_W;
  localparam int KEY_SEL_W       = $clog2(KEY_BYTES_TOTAL);
  localparam int KEY_LEN_W       = 6;
  localparam int KEY_LEN_RESET   = 16;
  localparam int MAX_KEY_BYTES_DEF = 32;
  localparam int CFG_IDX_W       = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3  = 3'd4;

  // Request handed from the port logic to the sequencer.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              rekey;
  } rc4_req_t;

  // Result handed back from the sequencer.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rc4_res_t;

endpackage

@@ design/rc4_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/rc4_add3.sv @@
// Shared modulo-256 three-input adder used for the j index and the keystream address.
module rc4_add3
  import rc4_pkg::*;
(
  input  logic [BYTE_W-1:0] a,
  input  logic [BYTE_W-1:0] b,
  input  logic [BYTE_W-1:0] c,
  output logic [BYTE_W-1:0] sum
);

  assign sum = a + b + c;

endmodule

@@ design/rc4_core.sv @@
// Sequencer for the RC4 key schedule and keystream generation around the permutation RAM.
module rc4_core
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
  localparam int LEN_W = POS_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rc4_req_t          req,
  output logic              idle,
  output logic [POS_W-1:0]  key_pos,
  input  logic [BYTE_W-1:0] key_byte,
  input  logic [LEN_W-1:0]  key_len,
  input  logic              res_ready,
  output rc4_res_t          res
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_FILL = 12'b0000_0000_0010,
    S_K_RS = 12'b0000_0000_0100,
    S_K_RJ = 12'b0000_0000_1000,
    S_K_WK = 12'b0000_0001_0000,
    S_K_WJ = 12'b0000_0010_0000,
    S_D_RI = 12'b0000_0100_0000,
    S_D_RJ = 12'b0000_1000_0000,
    S_D_WI = 12'b0001_0000_0000,
    S_D_WJ = 12'b0010_0000_0000,
    S_D_RT = 12'b0100_0000_0000,
    S_D_OUT = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [PERM_AW-1:0] k_r, k_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_W-1:0]  i_r, i_nxt;
  logic [BYTE_W-1:0]  j_r, j_nxt;
  logic [BYTE_W-1:0]  si_r, si_nxt;
  logic [BYTE_W-1:0]  sj_r, sj_nxt;
  logic [BYTE_W-1:0]  t_r, t_nxt;
  logic [BYTE_W-1:0]  data_r, data_nxt;
  logic               keyed_r, keyed_nxt;

  logic [BYTE_W-1:0]  add_a, add_b, add_c, add_sum;
  logic               ram_we, ram_re;
  logic [PERM_AW-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;
  logic [LEN_W-1:0]   pos_inc;
  logic               fire;

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rc4_add3 u_add (
    .a   (add_a),
    .b   (add_b),
    .c   (add_c),
    .sum (add_sum)
  );

  assign pos_inc = {1'b0, pos_r} + 1'b1;
  assign key_pos = pos_r;
  assign idle    = (state_r == S_IDLE);
  assign fire    = (state_r == S_D_OUT) && res_ready;

  assign res.valid = fire;
  assign res.data  = data_r ^ ram_rdata;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    t_nxt     = t_r;
    data_nxt  = data_r;
    keyed_nxt = keyed_r;
    add_a     = '0;
    add_b     = '0;
    add_c     = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          data_nxt = req.data;
          if (req.rekey || !keyed_r) begin
            k_nxt     = '0;
            state_nxt = S_FILL;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_D_RI;
          end
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = BYTE_W'(k_r);
        k_nxt     = k_r + 1'b1;
        if (k_r == PERM_AW'(PERM_DEPTH - 1)) begin
          j_nxt     = '0;
          pos_nxt   = '0;
          state_nxt = S_K_RS;
        end
      end
      S_K_RS: begin
        ram_re    = 1'b1;
        ram_raddr = k_r;
        state_nxt = S_K_RJ;
      end
      S_K_RJ: begin
        add_a     = j_r;
        add_b     = ram_rdata;
        add_c     = key_byte;
        si_nxt    = ram_rdata;
        j_nxt     = add_sum;
        ram_re    = 1'b1;
        ram_raddr = add_sum;
        pos_nxt   = (pos_inc >= key_len) ? '0 : pos_inc[POS_W-1:0];
        state_nxt = S_K_WK;
      end
      S_K_WK: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = ram_rdata;
        state_nxt = S_K_WJ;
      end
      S_K_WJ: begin
        // The write to S[j] comes last so that j equal to k leaves S[k] intact.
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = si_r;
        k_nxt     = k_r + 1'b1;
        if (k_r == PERM_AW'(PERM_DEPTH - 1)) begin
          i_nxt     = BYTE_W'(1);
          j_nxt     = '0;
          keyed_nxt = 1'b1;
          state_nxt = S_D_RI;
        end else begin
          state_nxt = S_K_RS;
        end
      end
      S_D_RI: begin
        ram_re    = 1'b1;
        ram_raddr = i_r;
        state_nxt = S_D_RJ;
      end
      S_D_RJ: begin
        add_a     = j_r;
        add_b     = ram_rdata;
        si_nxt    = ram_rdata;
        j_nxt     = add_sum;
        ram_re    = 1'b1;
        ram_raddr = add_sum;
        state_nxt = S_D_WI;
      end
      S_D_WI: begin
        sj_nxt    = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ram_rdata;
        state_nxt = S_D_WJ;
      end
      S_D_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = si_r;
        add_a     = si_r;
        add_b     = sj_r;
        t_nxt     = add_sum;
        state_nxt = S_D_RT;
      end
      S_D_RT: begin
        ram_re    = 1'b1;
        ram_raddr = t_r;
        state_nxt = S_D_OUT;
      end
      S_D_OUT: begin
        // Read data holds here until the output register can take the byte.
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      keyed_r <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      keyed_r <= keyed_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    pos_r  <= pos_nxt;
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    t_r    <= t_nxt;
    data_r <= data_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> idle)
    else $error("request started while the sequencer was busy");

  a_fire_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> idle)
    else $error("sequencer did not return to idle after a result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    idle |-> !ram_we)
    else $error("permutation RAM written while idle");

  a_keyed_before_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_RI) |-> keyed_r)
    else $error("keystream started without a key schedule");

endmodule

@@ design/rc4_stream_cipher.sv @@
// Top level of the RC4 byte cipher: configuration registers, request and result ports.
//
// Each accepted request carries one data byte and returns exactly one byte, the
// input XORed with the next RC4 keystream byte. The block works on one request at
// a time: in_ready is high only while the sequencer is idle. A plain data byte
// steps through the 256-entry permutation RAM, which has one write port and one
// read port: read S[i], read S[j], write S[i] and S[j] for the swap, read
// S[S[i]+S[j]], deliver. A request with in_first_of_message set, and the first
// request after reset whatever its flag, first runs the key schedule: it loads
// the identity permutation, then runs one swap step for each of the 256 entries
// (read S[k], read S[j], write S[k], write S[j]) before that byte is processed.
// A finished byte waits in an output register, so the next request is accepted
// while the previous result is still waiting to be taken; the sequencer stalls
// only if a second result is ready before the first has left. Key registers are
// sampled only during a key schedule. A key_length of zero acts as one and values
// above MAX_KEY_BYTES saturate. Configuration writes with an index beyond
// key_word3 are ignored. Configuration must only be written while no request is in flight.
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_WORD_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic                  in_first_of_message,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_byte
);

  localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int LEN_W = POS_W + 1;

  logic [KEY_LEN_W-1:0]  key_length_r;
  logic [KEY_WORD_W-1:0] key_word_r [KEY_WORDS];
  logic [KEY_WORDS*KEY_WORD_W-1:0] key_flat;

  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     out_byte_r;

  logic                  core_idle;
  logic                  start;
  rc4_req_t              req;
  rc4_res_t              res;
  logic                  res_ready;
  logic [POS_W-1:0]      key_pos;
  logic [KEY_SEL_W-1:0]  key_sel;
  logic [BYTE_W-1:0]     key_byte;
  logic [LEN_W-1:0]      key_len;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LEN_W'(KEY_LEN_RESET);
      for (int w = 0; w < KEY_WORDS; w++) begin
        key_word_r[w] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LENGTH: key_length_r  <= cfg_wdata[KEY_LEN_W-1:0];
        REG_KEY_WORD0:  key_word_r[0] <= cfg_wdata;
        REG_KEY_WORD1:  key_word_r[1] <= cfg_wdata;
        REG_KEY_WORD2:  key_word_r[2] <= cfg_wdata;
        REG_KEY_WORD3:  key_word_r[3] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Effective key length: zero acts as one, large values saturate.
  always_comb begin
    if (key_length_r == '0) begin
      key_len = LEN_W'(1);
    end else if (key_length_r > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      key_len = LEN_W'(MAX_KEY_BYTES);
    end else begin
      key_len = LEN_W'(key_length_r);
    end
  end

  // Key byte n sits at bits 8*n and up of the concatenated key words.
  assign key_flat = {key_word_r[3], key_word_r[2], key_word_r[1], key_word_r[0]};
  assign key_sel  = KEY_SEL_W'(key_pos);
  assign key_byte = key_flat[{key_sel, 3'b000} +: BYTE_W];

  // Request side: the sequencer takes a request only when idle.
  assign in_ready   = core_idle;
  assign start      = in_valid && core_idle;
  assign req.data   = in_data_byte;
  assign req.rekey  = in_first_of_message;

  rc4_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .idle      (core_idle),
    .key_pos   (key_pos),
    .key_byte  (key_byte),
    .key_len   (key_len),
    .res_ready (res_ready),
    .res       (res)
  );

  // Result side: one output register decouples the sequencer from the consumer.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_byte_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !res.valid)
    else $error("result overwrote a byte that was not taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request port stayed ready after accepting a request");

  a_result_registered: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> out_valid_r)
    else $error("result was not captured in the output register");

endmodule
